// ----- rtl/core/tcw_pkg.sv -----
// Shared constants, opcode codes and helper types for the task check-in watchdog.
// No dependencies; used by task_checkin_watchdog_unit.
package tcw_pkg;

  localparam int unsigned TICKS_PER_SECOND = 20;
  localparam int unsigned NUM_TASKS        = 16;

  localparam int unsigned MASK_W   = 16;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned PAUSE_W  = 21;
  localparam int unsigned SECS_W   = 16;
  localparam int unsigned TPS_W    = 6;
  localparam int unsigned PROD_W   = SECS_W + TPS_W;

  localparam logic [TICK_W-1:0]  WARN_TICKS  = TICK_W'(5 * TICKS_PER_SECOND);
  localparam logic [TICK_W-1:0]  RESET_TICKS = TICK_W'((65 * TICKS_PER_SECOND) / 10);
  localparam logic [TICK_W-1:0]  TICK_MAX    = {TICK_W{1'b1}};
  localparam logic [PAUSE_W-1:0] PAUSE_MAX   = {PAUSE_W{1'b1}};
  localparam logic [MASK_W-1:0]  ALL_TASKS   = MASK_W'((32'd1 << NUM_TASKS) - 32'd1);
  localparam logic [MASK_W-1:0]  WATCHED_RST = MASK_W'(8) & ALL_TASKS;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_STEP        = 3'd1,
    OP_CHECKIN     = 3'd2,
    OP_CHECKIN_ALL = 3'd3,
    OP_PAUSE       = 3'd4,
    OP_RESUME      = 3'd5
  } opcode_e;

  typedef struct packed {
    logic              feed_pulse;
    logic              warn_flag;
    logic              recovered_flag;
    logic              reset_request;
    logic [MASK_W-1:0] checkin_snapshot;
    logic [MASK_W-1:0] stuck_tasks;
    logic [TICK_W-1:0] ticks_unfed;
  } result_t;

endpackage

// ----- rtl/core/task_checkin_watchdog_unit.sv -----
// Task check-in watchdog: input register, combinational event evaluation, result register.
// Depends on tcw_pkg for constants, opcode codes and the result struct.
//
// Usage:
// The input channel (in_valid_i / in_stall_o) carries one event word: an opcode,
// a task id for check-ins and a pause length in seconds for pauses. Every
// accepted word produces exactly one result word on the output channel
// (out_valid_o / out_stall_i) with the feed, warning, recovery and reset-request
// flags, the check-in snapshot and stuck-task mask at a warning, and the tick
// count since the last feed.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes the watched-task
// mask; it is always ready and should only be written while the block is idle.
// The result is registered: it is offered from the result register once its word
// has passed from the input register into it. The block takes one word every cycle
// while the receiver does not stall: the watchdog state is updated in the cycle that
// moves a word from the input register into the result register.
// When the receiver stalls, the result register holds its word and the input
// register fills; once both are full, in_stall_o rises.
// Reset clears all watchdog state, empties both registers and sets the watched
// mask to task 3 alone.
module task_checkin_watchdog_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tcw_pkg::MASK_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 opcode_i,
  input  logic [3:0]                 task_id_i,
  input  logic [tcw_pkg::SECS_W-1:0] pause_seconds_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       feed_pulse_o,
  output logic                       warn_flag_o,
  output logic                       recovered_flag_o,
  output logic                       reset_request_o,
  output logic [tcw_pkg::MASK_W-1:0] checkin_snapshot_o,
  output logic [tcw_pkg::MASK_W-1:0] stuck_tasks_o,
  output logic [tcw_pkg::TICK_W-1:0] ticks_unfed_o
);

  logic [tcw_pkg::MASK_W-1:0]  watched_q;
  logic [tcw_pkg::MASK_W-1:0]  checkin_q, checkin_d;
  logic [tcw_pkg::PAUSE_W-1:0] pause_q, pause_d;
  logic [tcw_pkg::TICK_W-1:0]  unfed_q, unfed_d;
  logic [tcw_pkg::TICK_W-1:0]  last_warn_q, last_warn_d;

  logic                        in_valid_q;
  logic [2:0]                  opcode_q;
  logic [3:0]                  task_q;
  logic [tcw_pkg::SECS_W-1:0]  secs_q;

  logic                        out_valid_q;
  tcw_pkg::result_t            res_q, res_d;

  logic                        out_hold;
  logic                        advance;
  logic [tcw_pkg::TICK_W-1:0]  unfed_adv;
  logic [tcw_pkg::PROD_W-1:0]  pause_prod;
  logic                        all_in;

  assign cfg_ready_o = 1'b1;
  assign out_hold    = out_valid_q && out_stall_i;
  assign in_stall_o  = in_valid_q && out_hold;
  assign advance     = in_valid_q && !out_hold;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      opcode_q <= opcode_i;
      task_q   <= task_id_i;
      secs_q   <= pause_seconds_i;
    end
  end

  // Event evaluation.
  assign pause_prod = secs_q * tcw_pkg::TPS_W'(tcw_pkg::TICKS_PER_SECOND);
  assign all_in     = (checkin_q & watched_q) == watched_q;

  always_comb begin
    checkin_d   = checkin_q;
    pause_d     = pause_q;
    unfed_d     = unfed_q;
    last_warn_d = last_warn_q;
    res_d       = '0;
    unfed_adv   = unfed_q;

    unique case (opcode_q)
      tcw_pkg::OP_TICK, tcw_pkg::OP_STEP: begin
        if (opcode_q == tcw_pkg::OP_TICK && unfed_q != tcw_pkg::TICK_MAX) begin
          unfed_adv = unfed_q + 1'b1;
        end
        unfed_d = unfed_adv;
        if (pause_q != '0) begin
          pause_d          = pause_q - 1'b1;
          unfed_d          = '0;
          res_d.feed_pulse = 1'b1;
        end else if (all_in) begin
          // A feed clears the tick count, so no warning can follow in the same step.
          checkin_d        = '0;
          unfed_d          = '0;
          res_d.feed_pulse = 1'b1;
          if (last_warn_q != '0) begin
            res_d.recovered_flag = 1'b1;
            last_warn_d          = '0;
          end
        end else if (unfed_adv >= tcw_pkg::WARN_TICKS && unfed_adv > last_warn_q) begin
          res_d.warn_flag        = 1'b1;
          res_d.checkin_snapshot = checkin_q;
          res_d.stuck_tasks      = watched_q & ~checkin_q;
          res_d.reset_request    = unfed_adv >= tcw_pkg::RESET_TICKS;
          last_warn_d            = unfed_adv;
        end
      end
      tcw_pkg::OP_CHECKIN: begin
        if ({1'b0, task_q} < 5'(tcw_pkg::NUM_TASKS)) begin
          checkin_d = checkin_q | (tcw_pkg::MASK_W'(1) << task_q);
        end
      end
      tcw_pkg::OP_CHECKIN_ALL: begin
        checkin_d = checkin_q | watched_q;
      end
      tcw_pkg::OP_PAUSE: begin
        if (pause_prod > tcw_pkg::PROD_W'(tcw_pkg::PAUSE_MAX)) begin
          pause_d = tcw_pkg::PAUSE_MAX;
        end else begin
          pause_d = pause_prod[tcw_pkg::PAUSE_W-1:0];
        end
      end
      tcw_pkg::OP_RESUME: begin
        pause_d = '0;
      end
      default: begin
      end
    endcase

    res_d.ticks_unfed = unfed_d;
  end

  // Watchdog state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watched_q   <= tcw_pkg::WATCHED_RST;
      checkin_q   <= '0;
      pause_q     <= '0;
      unfed_q     <= '0;
      last_warn_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        watched_q <= cfg_data_i & tcw_pkg::ALL_TASKS;
      end
      if (advance) begin
        checkin_q   <= checkin_d;
        pause_q     <= pause_d;
        unfed_q     <= unfed_d;
        last_warn_q <= last_warn_d;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_hold) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign feed_pulse_o       = res_q.feed_pulse;
  assign warn_flag_o        = res_q.warn_flag;
  assign recovered_flag_o   = res_q.recovered_flag;
  assign reset_request_o    = res_q.reset_request;
  assign checkin_snapshot_o = res_q.checkin_snapshot;
  assign stuck_tasks_o      = res_q.stuck_tasks;
  assign ticks_unfed_o      = res_q.ticks_unfed;

  // A feed and a warning never come from the same word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.feed_pulse && res_q.warn_flag))
    else $error("feed and warning in one word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.reset_request) |-> res_q.warn_flag)
    else $error("reset request without warning");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.recovered_flag) |-> res_q.feed_pulse)
    else $error("recovery without feed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.feed_pulse) |-> (res_q.ticks_unfed == '0))
    else $error("feed left a nonzero tick count");

  // The state only moves when a word passes into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(unfed_q) && $stable(checkin_q) && $stable(pause_q)))
    else $error("watchdog state changed without a word");

endmodule
